@@ sv/ncds_pkg.sv @@
// ----------------------------------------------------------------------------
// ncds_pkg: shared types and constants of the note command synthesizer
// Word formats, event codes, note step table and sine table builder.
// ----------------------------------------------------------------------------
package ncds_pkg;

  // sizing
  localparam int TABLE_DEPTH    = 1024;
  localparam int LINE_DEPTH     = 32;
  localparam int SAMPLE_BITS    = 12;
  localparam int FRAC_BITS      = 16;
  localparam int TABLE_BITS     = $clog2(TABLE_DEPTH);
  localparam int PHASE_BITS     = TABLE_BITS + FRAC_BITS;
  localparam int STEP_BITS      = FRAC_BITS + 3;
  localparam int LCOUNT_BITS    = $clog2(LINE_DEPTH);
  localparam int OUT_STEP_BITS  = 19;
  localparam int NOTE_COUNT     = 12;

  // phase wraps at table length in fixed point
  localparam logic [PHASE_BITS:0] PHASE_MOD =
    (PHASE_BITS + 1)'(longint'(TABLE_DEPTH) << FRAC_BITS);

  // mid-scale dac value
  localparam logic [SAMPLE_BITS-1:0] CENTER = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

  // line store positions of the note name
  localparam logic [LCOUNT_BITS-1:0] NAME_POS2 = LCOUNT_BITS'(2);
  localparam logic [LCOUNT_BITS-1:0] NAME_POS3 = LCOUNT_BITS'(3);
  localparam logic [LCOUNT_BITS-1:0] NAME_POS4 = LCOUNT_BITS'(4);

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_F     = 8'h46;

  // result event codes
  typedef enum logic [2:0] {
    EV_SAMPLE   = 3'd0,
    EV_BYTE     = 3'd1,
    EV_NOTE_ON  = 3'd2,
    EV_NOTE_OFF = 3'd3,
    EV_IGNORED  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_word_t;

  typedef struct packed {
    event_kind_t              event_kind;
    logic [SAMPLE_BITS-1:0]   sample;
    logic [OUT_STEP_BITS-1:0] phase_step;
    logic                     led_on;
  } result_word_t;

  // note names, two-character names padded with a zero byte
  localparam logic [1:0] NOTE_LEN [NOTE_COUNT] = '{
    2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2
  };
  localparam logic [23:0] NOTE_TXT [NOTE_COUNT] = '{
    {"C4", 8'h00}, "C#4", {"D4", 8'h00}, "D#4", {"E4", 8'h00}, {"F4", 8'h00},
    "F#4", {"G4", 8'h00}, "G#4", {"A4", 8'h00}, "A#4", {"B4", 8'h00}
  };
  localparam logic [8:0] NOTE_HUND [NOTE_COUNT] = '{
    9'd240, 9'd260, 9'd273, 9'd284, 9'd310, 9'd324,
    9'd345, 9'd362, 9'd386, 9'd400, 9'd425, 9'd450
  };

  // step in fixed point from a value in hundredths, rounded
  function automatic logic [STEP_BITS-1:0] step_of(input int unsigned hundredths);
    longint unsigned v;
    v = ((longint'(hundredths) << FRAC_BITS) + 50) / 100;
    return STEP_BITS'(v);
  endfunction

  typedef logic [STEP_BITS-1:0] note_steps_t [NOTE_COUNT];

  function automatic note_steps_t build_note_steps();
    note_steps_t steps;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      steps[i] = step_of(int'(NOTE_HUND[i]));
    end
    return steps;
  endfunction

  localparam note_steps_t PITCH_STEP = build_note_steps();
  localparam logic [STEP_BITS-1:0] RESET_STEP = step_of(480);

  // match a two or three character name against the note list
  function automatic logic [STEP_BITS-1:0] note_lookup(input logic [7:0] b2,
                                                       input logic [7:0] b3,
                                                       input logic [7:0] b4,
                                                       input logic       n3);
    logic [STEP_BITS-1:0] hit;
    logic [23:0]          name;
    logic [1:0]           nlen;
    hit  = '0;
    name = {b2, b3, (n3 ? b4 : CH_NUL)};
    nlen = n3 ? 2'd3 : 2'd2;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (NOTE_LEN[i] == nlen && NOTE_TXT[i] == name) begin
        hit = PITCH_STEP[i];
      end
    end
    return hit;
  endfunction

  // sine table, q30 series evaluated at elaboration
  localparam int              Q_SHIFT     = 30;
  localparam longint unsigned Q_ONE       = 64'd1 << Q_SHIFT;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // series divisors (2k)(2k+1) for k = 1..7
  localparam longint unsigned SERIES_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  function automatic longint unsigned sin_q30(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (r * HALF_PI_Q30) / TABLE_DEPTH;
    x2   = (x * x) >> Q_SHIFT;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> Q_SHIFT;
      term = term / SERIES_DIV[k - 1];
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > Q_ONE) sum = Q_ONE;
    return sum;
  endfunction

  typedef logic [SAMPLE_BITS-1:0] wave_lut_t [TABLE_DEPTH];

  function automatic wave_lut_t build_sine();
    wave_lut_t       tbl;
    longint unsigned c;
    longint unsigned q4;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned m;
    longint unsigned v;
    c = longint'(CENTER);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      q4  = longint'(4 * i);
      q   = q4 / TABLE_DEPTH;
      rem = q4 % TABLE_DEPTH;
      if (rem == 0) m = ((q & 1) != 0) ? Q_ONE : 64'd0;
      else m = sin_q30(((q & 1) != 0) ? longint'(TABLE_DEPTH) - rem : rem);
      if (q >= 2) v = (c << Q_SHIFT) - c * m;
      else v = (c << Q_SHIFT) + c * m;
      tbl[i] = SAMPLE_BITS'(v >> Q_SHIFT);
    end
    return tbl;
  endfunction

  localparam wave_lut_t WAVE_LUT = build_sine();

endpackage

@@ sv/ncds_ram.sv @@
// ----------------------------------------------------------------------------
// ncds_ram: generic single-port-write, single-port-read ram
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module ncds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/note_command_dds_synth.sv @@
// ----------------------------------------------------------------------------
// note_command_dds_synth: serial note command parser with sine nco
// Bytes build command lines; sample ticks read the sine rom at the phase.
// ----------------------------------------------------------------------------
// Usage
//   item channel: one word per cycle, cmd 0 carries a received byte, cmd 1 a
//   sample tick. result channel: exactly one word per item, in order.
//   Each result word is registered into the output buffer; after a note name
//   read-back (below) it is pushed from P_END. Throughput: while not stalled,
//   one item per cycle for ticks and ordinary bytes. The sine rom
//   is read one tick ahead at the next phase, so ticks run back to back.
//   A newline that ends an N: line with a two or three character name starts
//   a read-back: the name is read from the line store over its single read
//   port (3 reads, one per cycle) and no item is taken meanwhile.
//   Reset: line store empty (its contents stay unknown and are never read
//   before written), phase 0, step 4.80 in fixed point, lamp off. No
//   clearing pass; items are taken as soon as reset is low.
//   Stall: a two-word output buffer sits in front of the result channel; the
//   item channel keeps accepting until its second word is occupied.
// ----------------------------------------------------------------------------
module note_command_dds_synth (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  ncds_pkg::item_word_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output ncds_pkg::result_word_t result
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_B3,
    P_B4,
    P_END
  } parse_state_t;

  parse_state_t p_state;
  logic [7:0]   name_b2;
  logic [7:0]   name_b3;
  logic         name_n3;

  logic [ncds_pkg::LCOUNT_BITS-1:0] line_count;
  logic [ncds_pkg::LCOUNT_BITS-1:0] zero_pos;
  logic                             zero_seen;
  logic                             hdr_n;
  logic                             hdr_f;
  logic                             hdr_colon;

  logic [ncds_pkg::PHASE_BITS-1:0]  phase;
  logic [ncds_pkg::PHASE_BITS-1:0]  phase_next;
  logic [ncds_pkg::PHASE_BITS:0]    phase_sum;
  logic [ncds_pkg::STEP_BITS-1:0]   step_now;
  logic [ncds_pkg::STEP_BITS-1:0]   step_next;
  logic [ncds_pkg::STEP_BITS-1:0]   name_step;
  logic                             lamp;
  logic                             lamp_next;

  logic [ncds_pkg::TABLE_BITS-1:0]  rom_addr;
  logic [ncds_pkg::SAMPLE_BITS-1:0] rom_q;

  logic [ncds_pkg::LCOUNT_BITS-1:0] ram_raddr;
  logic [7:0]                       ram_rdata;

  logic                             accept;
  logic                             take_tick;
  logic                             take_byte;
  logic                             is_nl;
  logic                             stored;
  logic                             trailing_nl;
  logic                             line_ok;
  logic                             name_fits;
  logic                             start_parse;
  logic                             parse_end;
  logic [ncds_pkg::LCOUNT_BITS-1:0] line_len;
  logic [ncds_pkg::LCOUNT_BITS-1:0] name_len;

  logic                             push;
  logic                             pop;
  ncds_pkg::event_kind_t            push_kind;
  logic [ncds_pkg::SAMPLE_BITS-1:0] push_sample;
  ncds_pkg::result_word_t           push_word;
  logic                             skid_valid;
  ncds_pkg::result_word_t           skid_word;

  // handshake and item decode
  assign item_ready = !rst && (p_state == P_IDLE) && !skid_valid;
  assign accept     = item_valid && item_ready;
  assign take_tick  = accept && item.cmd;
  assign take_byte  = accept && !item.cmd;
  assign pop        = result_valid && result_ready;
  assign parse_end  = (p_state == P_END);

  // line end checks from the header flags and first zero position
  always_comb begin
    is_nl       = (item.rx_byte == ncds_pkg::CH_NL);
    stored      = (line_count != ncds_pkg::LCOUNT_BITS'(ncds_pkg::LINE_DEPTH - 1));
    trailing_nl = !zero_seen && stored;
    if (zero_seen) line_len = zero_pos;
    else if (stored) line_len = line_count + ncds_pkg::LCOUNT_BITS'(1);
    else line_len = line_count;
    line_ok     = (line_len > ncds_pkg::LCOUNT_BITS'(3)) && hdr_colon && (hdr_n || hdr_f);
    name_len    = line_len - ncds_pkg::LCOUNT_BITS'(2) - ncds_pkg::LCOUNT_BITS'(trailing_nl);
    name_fits   = (name_len == ncds_pkg::LCOUNT_BITS'(2)) ||
                  (name_len == ncds_pkg::LCOUNT_BITS'(3));
    start_parse = take_byte && is_nl && line_ok && hdr_n && name_fits;
  end

  // note name match on the bytes read back
  assign name_step = ncds_pkg::note_lookup(name_b2, name_b3, ram_rdata, name_n3);

  // phase accumulator with wrap; rom is addressed at the next phase
  always_comb begin
    phase_sum  = {1'b0, phase} + (ncds_pkg::PHASE_BITS + 1)'(step_now);
    phase_next = phase;
    if (take_tick && (step_now != '0)) begin
      if (phase_sum >= ncds_pkg::PHASE_MOD) begin
        phase_next = ncds_pkg::PHASE_BITS'(phase_sum - ncds_pkg::PHASE_MOD);
      end else begin
        phase_next = ncds_pkg::PHASE_BITS'(phase_sum);
      end
    end
    rom_addr = rst ? '0 : phase_next[ncds_pkg::PHASE_BITS-1:ncds_pkg::FRAC_BITS];
  end

  // result word and next step / lamp
  always_comb begin
    step_next   = step_now;
    lamp_next   = lamp;
    push        = 1'b0;
    push_kind   = ncds_pkg::EV_BYTE;
    push_sample = '0;
    if (parse_end) begin
      step_next = name_step;
      lamp_next = 1'b1;
      push      = 1'b1;
      push_kind = ncds_pkg::EV_NOTE_ON;
    end else if (take_tick) begin
      push        = 1'b1;
      push_kind   = ncds_pkg::EV_SAMPLE;
      push_sample = (step_now != '0) ? rom_q : ncds_pkg::CENTER;
    end else if (take_byte) begin
      push = !start_parse;
      if (is_nl) begin
        if (!line_ok) begin
          push_kind = ncds_pkg::EV_IGNORED;
        end else if (hdr_f) begin
          step_next = '0;
          lamp_next = 1'b0;
          push_kind = ncds_pkg::EV_NOTE_OFF;
        end else begin
          step_next = '0;
          lamp_next = 1'b1;
          push_kind = ncds_pkg::EV_NOTE_ON;
        end
      end
    end
    push_word = '{event_kind: push_kind,
                  sample:     push_sample,
                  phase_step: ncds_pkg::OUT_STEP_BITS'(step_next),
                  led_on:     lamp_next};
  end

  // line bookkeeping, phase, step and lamp
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      zero_seen  <= 1'b0;
      phase      <= '0;
      step_now   <= ncds_pkg::RESET_STEP;
      lamp       <= 1'b0;
    end else begin
      phase    <= phase_next;
      step_now <= step_next;
      lamp     <= lamp_next;
      if (take_byte) begin
        if (is_nl) begin
          line_count <= '0;
          zero_seen  <= 1'b0;
        end else if (stored) begin
          line_count <= line_count + ncds_pkg::LCOUNT_BITS'(1);
        end
        if (stored) begin
          if (line_count == '0) begin
            hdr_n <= (item.rx_byte == ncds_pkg::CH_N);
            hdr_f <= (item.rx_byte == ncds_pkg::CH_F);
          end
          if (line_count == ncds_pkg::LCOUNT_BITS'(1)) begin
            hdr_colon <= (item.rx_byte == ncds_pkg::CH_COLON);
          end
          if (!zero_seen && (item.rx_byte == ncds_pkg::CH_NUL)) begin
            zero_seen <= 1'b1;
            zero_pos  <= line_count;
          end
        end
      end
    end
  end

  // name read-back sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      p_state <= P_IDLE;
    end else begin
      case (p_state)
        P_IDLE: begin
          if (start_parse) begin
            p_state <= P_B3;
            name_n3 <= (name_len == ncds_pkg::LCOUNT_BITS'(3));
          end
        end
        P_B3: begin
          name_b2 <= ram_rdata;
          p_state <= P_B4;
        end
        P_B4: begin
          name_b3 <= ram_rdata;
          p_state <= P_END;
        end
        P_END: begin
          p_state <= P_IDLE;
        end
        default: begin
          p_state <= P_IDLE;
        end
      endcase
    end
  end

  // read address follows the sequencer; idle prefetches the first name byte
  always_comb begin
    case (p_state)
      P_B3:    ram_raddr = ncds_pkg::NAME_POS3;
      P_B4:    ram_raddr = ncds_pkg::NAME_POS4;
      default: ram_raddr = ncds_pkg::NAME_POS2;
    endcase
  end

  // line store
  ncds_ram #(
    .WIDTH (8),
    .DEPTH (ncds_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (take_byte && stored),
    .waddr (line_count),
    .wdata (item.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sine rom, registered read
  always_ff @(posedge clk) begin
    rom_q <= ncds_pkg::WAVE_LUT[rom_addr];
  end

  // two-word output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        result     <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!result_valid || pop) begin
        result       <= push_word;
        result_valid <= 1'b1;
      end else begin
        skid_word  <= push_word;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid word held with empty output register");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result word produced with output buffer full");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, phase} < ncds_pkg::PHASE_MOD)
    else $error("phase outside table range");

  a_step_on_line_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (step_now != $past(step_now))) |->
      $past(parse_end || (take_byte && is_nl)))
    else $error("step changed without a line end");

  a_phase_on_tick: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (phase != $past(phase))) |-> $past(take_tick))
    else $error("phase moved without a sample tick");

endmodule
